/* rtl/core/c8alu_pkg.sv */
// c8alu_pkg: shared types and constants for the 8-bit ALU with flags.
// Used by the decode, execute and flag stages and by the top level.
// No dependencies.
package c8alu_pkg;

	localparam int WORD_W = 16;
	localparam int BYTE_W = 8;
	localparam int FLAG_W = 4;

	// flag positions in the 4-bit flag word
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// decimal adjust thresholds and corrections
	localparam logic [3:0] DAA_NIB_MAX = 4'h9;
	localparam logic [7:0] DAA_BYTE_MAX = 8'h99;
	localparam logic [7:0] DAA_ADJ_LO = 8'h06;
	localparam logic [7:0] DAA_ADJ_HI = 8'h60;

	typedef enum logic [4:0] {
		OP_ADD    = 5'd0,
		OP_ADC    = 5'd1,
		OP_SUB    = 5'd2,
		OP_SBC    = 5'd3,
		OP_AND    = 5'd4,
		OP_XOR    = 5'd5,
		OP_OR     = 5'd6,
		OP_CP     = 5'd7,
		OP_INC    = 5'd8,
		OP_DEC    = 5'd9,
		OP_RLCA   = 5'd10,
		OP_RRCA   = 5'd11,
		OP_RLA    = 5'd12,
		OP_RRA    = 5'd13,
		OP_DAA    = 5'd14,
		OP_CPL    = 5'd15,
		OP_SCF    = 5'd16,
		OP_CCF    = 5'd17,
		OP_RLC    = 5'd18,
		OP_RRC    = 5'd19,
		OP_RL     = 5'd20,
		OP_RR     = 5'd21,
		OP_SLA    = 5'd22,
		OP_SRA    = 5'd23,
		OP_SWAP   = 5'd24,
		OP_SRL    = 5'd25,
		OP_BIT    = 5'd26,
		OP_RES    = 5'd27,
		OP_SET    = 5'd28,
		OP_ADD16  = 5'd29,
		OP_ADD16S = 5'd30
	} op_t;

	// raw input item
	typedef struct packed {
		logic [4:0]        func;
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] opnd;
		logic [2:0]        bit_idx;
		logic [FLAG_W-1:0] fin;
	} in_t;

	// after decode: adder operands prepared
	typedef struct packed {
		logic [4:0]        func;
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] opnd;
		logic [2:0]        bit_idx;
		logic [FLAG_W-1:0] fin;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic              cy;
		logic              daa_c;
	} dec_t;

	// after execute: raw value plus carry taps
	typedef struct packed {
		logic [4:0]        func;
		logic [FLAG_W-1:0] fin;
		logic [WORD_W-1:0] res;
		logic [BYTE_W-1:0] zval;
		logic              c4;
		logic              c8;
		logic              c12;
		logic              c16;
		logic              sout;
		logic              bitz;
		logic              daa_c;
	} exe_t;

	// result item
	typedef struct packed {
		logic              wr;
		logic [FLAG_W-1:0] flags;
		logic [WORD_W-1:0] res;
	} out_t;

endpackage

/* rtl/core/cpu8_alu_with_flags_core.sv */
// cpu8_alu_with_flags_core: top level of the 8-bit CPU ALU with Z/N/H/C flags.
// Instantiates c8alu_decode, c8alu_exec and c8alu_flags; depends on c8alu_pkg.
//
//   channel   | dir | width | fields (lowest bit first)
//   ----------+-----+-------+---------------------------------------------------
//   s_axis    | in  | 48    | func[4:0] acc_in[20:5] operand_in[36:21]
//             |     |       | bit_index[39:37] flags_in[43:40] zero[47:44]
//   m_axis    | out | 24    | result[15:0] flags_out[19:16] write_result[20]
//             |     |       | zero[23:21]
//
// Pipeline: three register stages (decode, execute, flags), one transfer per cycle while
// m_axis_tready is high. The input transfer loads decode; the item then passes through
// the execute and flags registers, and the flags register drives m_axis.
// Every stage takes a new item whenever it is empty or its contents move on in the
// same cycle.
// Reset: arst_n clears only the stage valid bits; payload registers are not reset.
// Stalls: m_axis_tready low holds the output register; upstream stages keep
// filling until full, so bubbles squeeze out and no item is dropped or repeated.
module cpu8_alu_with_flags_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// func, acc_in, operand_in, bit_index, flags_in, zero pad
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result, flags_out, write_result, zero pad
	output logic [23:0] m_axis_tdata
);

	c8alu_pkg::in_t    in_item;
	c8alu_pkg::dec_t   dec_s1;
	c8alu_pkg::exe_t   exe_s2;
	c8alu_pkg::out_t   out_s3;
	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic              rdy_s2;
	logic              rdy_s3;

	// unpack the slave-side tdata
	assign in_item.func    = s_axis_tdata[4:0];
	assign in_item.acc     = s_axis_tdata[20:5];
	assign in_item.opnd    = s_axis_tdata[36:21];
	assign in_item.bit_idx = s_axis_tdata[39:37];
	assign in_item.fin     = s_axis_tdata[43:40];

	// stage 1: operand select, carry-in, decimal adjust correction
	c8alu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (in_item),
		.out_valid (v_s1),
		.out_ready (rdy_s2),
		.out_data  (dec_s1)
	);

	// stage 2: adder, logic, shifter, bit ops
	c8alu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (rdy_s2),
		.in_data   (dec_s1),
		.out_valid (v_s2),
		.out_ready (rdy_s3),
		.out_data  (exe_s2)
	);

	// stage 3: flag assembly and write-back enable; this register drives m_axis
	c8alu_flags u_flags (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (rdy_s3),
		.in_data   (exe_s2),
		.out_valid (v_s3),
		.out_ready (m_axis_tready),
		.out_data  (out_s3)
	);

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {3'b000, out_s3.wr, out_s3.flags, out_s3.res};

	// an empty first stage always takes a transfer
	a_s1_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_axis_tready)
		else $error("input stalled with decode stage empty");

	// a full pipe behind a stalled output must push back on the input
	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted into a full stalled pipeline");

	// an accepted transfer lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted item missing from decode stage");

	// an item in stage 2 moves into an empty output register
	a_s2_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !v_s3) |=> v_s3)
		else $error("execute stage item not forwarded to empty output");

endmodule

/* rtl/core/c8alu_decode.sv */
// c8alu_decode: first pipeline stage; picks adder operands and carry-in,
// works out the decimal adjust correction. Depends on c8alu_pkg.
module c8alu_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  c8alu_pkg::in_t      in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output c8alu_pkg::dec_t     out_data
);

	logic                              valid_s1;
	c8alu_pkg::dec_t                   data_s1;
	c8alu_pkg::dec_t                   dec;
	logic [c8alu_pkg::BYTE_W-1:0]      a;
	logic [c8alu_pkg::BYTE_W-1:0]      b;
	logic [c8alu_pkg::BYTE_W-1:0]      adj;
	logic                              cin;
	logic                              hin;

	assign a   = in_data.acc[c8alu_pkg::BYTE_W-1:0];
	assign b   = in_data.opnd[c8alu_pkg::BYTE_W-1:0];
	assign cin = in_data.fin[c8alu_pkg::FLAG_C];
	assign hin = in_data.fin[c8alu_pkg::FLAG_H];

	always_comb begin
		dec.func    = in_data.func;
		dec.acc     = in_data.acc;
		dec.opnd    = in_data.opnd;
		dec.bit_idx = in_data.bit_idx;
		dec.fin     = in_data.fin;
		dec.x       = '0;
		dec.y       = '0;
		dec.cy      = 1'b0;
		dec.daa_c   = cin;
		adj         = '0;
		unique case (c8alu_pkg::op_t'(in_data.func))
			c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC: begin
				dec.x  = {8'h00, a};
				dec.y  = {8'h00, b};
				dec.cy = (in_data.func == c8alu_pkg::OP_ADC) ? cin : 1'b0;
			end
			// subtract as a + ~b + 1 - borrow
			c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC, c8alu_pkg::OP_CP: begin
				dec.x  = {8'h00, a};
				dec.y  = {8'h00, ~b};
				dec.cy = (in_data.func == c8alu_pkg::OP_SBC) ? ~cin : 1'b1;
			end
			c8alu_pkg::OP_INC: begin
				dec.x  = {8'h00, b};
				dec.cy = 1'b1;
			end
			c8alu_pkg::OP_DEC: begin
				dec.x = {8'h00, b};
				dec.y = 16'h00FF;
			end
			c8alu_pkg::OP_DAA: begin
				dec.x = {8'h00, a};
				if (!in_data.fin[c8alu_pkg::FLAG_N]) begin
					if (hin || (a[3:0] > c8alu_pkg::DAA_NIB_MAX))
						adj = adj | c8alu_pkg::DAA_ADJ_LO;
					if (cin || (a > c8alu_pkg::DAA_BYTE_MAX)) begin
						adj       = adj | c8alu_pkg::DAA_ADJ_HI;
						dec.daa_c = 1'b1;
					end
					dec.y = {8'h00, adj};
				end else begin
					if (hin)
						adj = adj | c8alu_pkg::DAA_ADJ_LO;
					if (cin)
						adj = adj | c8alu_pkg::DAA_ADJ_HI;
					dec.y  = {8'h00, ~adj};
					dec.cy = 1'b1;
				end
			end
			c8alu_pkg::OP_ADD16: begin
				dec.x = in_data.acc;
				dec.y = in_data.opnd;
			end
			c8alu_pkg::OP_ADD16S: begin
				dec.x = in_data.acc;
				dec.y = {{8{b[7]}}, b};
			end
			default: begin
				dec.x = '0;
			end
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= dec;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

/* rtl/core/c8alu_exec.sv */
// c8alu_exec: second pipeline stage; 17-bit adder with carry taps, logic
// ops, shifts, rotates and bit ops. Depends on c8alu_pkg.
module c8alu_exec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  c8alu_pkg::dec_t     in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output c8alu_pkg::exe_t     out_data
);

	logic                              valid_s2;
	c8alu_pkg::exe_t                   data_s2;
	c8alu_pkg::exe_t                   exe;
	logic [c8alu_pkg::WORD_W:0]        sum;
	logic [c8alu_pkg::WORD_W-1:0]      cvec;
	logic [c8alu_pkg::BYTE_W-1:0]      a;
	logic [c8alu_pkg::BYTE_W-1:0]      b;
	logic [c8alu_pkg::BYTE_W-1:0]      mask;
	logic                              cin;

	assign a    = in_data.acc[c8alu_pkg::BYTE_W-1:0];
	assign b    = in_data.opnd[c8alu_pkg::BYTE_W-1:0];
	assign cin  = in_data.fin[c8alu_pkg::FLAG_C];
	assign mask = 8'h01 << in_data.bit_idx;
	assign sum  = {1'b0, in_data.x} + {1'b0, in_data.y} + {16'h0000, in_data.cy};
	// carry into each bit position
	assign cvec = in_data.x ^ in_data.y ^ sum[c8alu_pkg::WORD_W-1:0];

	always_comb begin
		exe.func  = in_data.func;
		exe.fin   = in_data.fin;
		exe.res   = '0;
		exe.sout  = 1'b0;
		exe.c4    = cvec[4];
		exe.c8    = cvec[8];
		exe.c12   = cvec[12];
		exe.c16   = sum[c8alu_pkg::WORD_W];
		exe.bitz  = ~b[in_data.bit_idx];
		exe.daa_c = in_data.daa_c;
		unique case (c8alu_pkg::op_t'(in_data.func))
			c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC, c8alu_pkg::OP_SUB,
			c8alu_pkg::OP_SBC, c8alu_pkg::OP_INC, c8alu_pkg::OP_DEC,
			c8alu_pkg::OP_DAA:
				exe.res = {8'h00, sum[7:0]};
			c8alu_pkg::OP_CP, c8alu_pkg::OP_SCF, c8alu_pkg::OP_CCF:
				exe.res = {8'h00, a};
			c8alu_pkg::OP_AND:  exe.res = {8'h00, a & b};
			c8alu_pkg::OP_XOR:  exe.res = {8'h00, a ^ b};
			c8alu_pkg::OP_OR:   exe.res = {8'h00, a | b};
			c8alu_pkg::OP_CPL:  exe.res = {8'h00, ~a};
			c8alu_pkg::OP_RLCA: begin
				exe.res  = {8'h00, a[6:0], a[7]};
				exe.sout = a[7];
			end
			c8alu_pkg::OP_RRCA: begin
				exe.res  = {8'h00, a[0], a[7:1]};
				exe.sout = a[0];
			end
			c8alu_pkg::OP_RLA: begin
				exe.res  = {8'h00, a[6:0], cin};
				exe.sout = a[7];
			end
			c8alu_pkg::OP_RRA: begin
				exe.res  = {8'h00, cin, a[7:1]};
				exe.sout = a[0];
			end
			c8alu_pkg::OP_RLC: begin
				exe.res  = {8'h00, b[6:0], b[7]};
				exe.sout = b[7];
			end
			c8alu_pkg::OP_RRC: begin
				exe.res  = {8'h00, b[0], b[7:1]};
				exe.sout = b[0];
			end
			c8alu_pkg::OP_RL: begin
				exe.res  = {8'h00, b[6:0], cin};
				exe.sout = b[7];
			end
			c8alu_pkg::OP_RR: begin
				exe.res  = {8'h00, cin, b[7:1]};
				exe.sout = b[0];
			end
			c8alu_pkg::OP_SLA: begin
				exe.res  = {8'h00, b[6:0], 1'b0};
				exe.sout = b[7];
			end
			c8alu_pkg::OP_SRA: begin
				exe.res  = {8'h00, b[7], b[7:1]};
				exe.sout = b[0];
			end
			c8alu_pkg::OP_SWAP: exe.res = {8'h00, b[3:0], b[7:4]};
			c8alu_pkg::OP_SRL: begin
				exe.res  = {8'h00, 1'b0, b[7:1]};
				exe.sout = b[0];
			end
			c8alu_pkg::OP_BIT:  exe.res = {8'h00, b};
			c8alu_pkg::OP_RES:  exe.res = {8'h00, b & ~mask};
			c8alu_pkg::OP_SET:  exe.res = {8'h00, b | mask};
			c8alu_pkg::OP_ADD16, c8alu_pkg::OP_ADD16S:
				exe.res = sum[c8alu_pkg::WORD_W-1:0];
			default: exe.res = '0;
		endcase
		// compare sets Z from the difference, not from the kept accumulator
		exe.zval = (in_data.func == c8alu_pkg::OP_CP) ? sum[7:0] :
			exe.res[c8alu_pkg::BYTE_W-1:0];
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= exe;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* rtl/core/c8alu_flags.sv */
// c8alu_flags: third pipeline stage; assembles Z/N/H/C and the write-back
// enable, and holds the output register. Depends on c8alu_pkg.
module c8alu_flags (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  c8alu_pkg::exe_t     in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output c8alu_pkg::out_t     out_data
);

	logic                              valid_s3;
	c8alu_pkg::out_t                   data_s3;
	c8alu_pkg::out_t                   fo;
	logic                              z;
	logic                              cin;
	logic [c8alu_pkg::FLAG_W-1:0]      fin;

	assign fin = in_data.fin;
	assign cin = fin[c8alu_pkg::FLAG_C];
	assign z   = (in_data.zval == '0);

	// flag word order: Z N H C
	always_comb begin
		fo.res   = in_data.res;
		fo.flags = fin;
		fo.wr    = 1'b1;
		unique case (c8alu_pkg::op_t'(in_data.func))
			c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC:
				fo.flags = {z, 1'b0, in_data.c4, in_data.c8};
			c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC:
				fo.flags = {z, 1'b1, ~in_data.c4, ~in_data.c8};
			c8alu_pkg::OP_CP: begin
				fo.flags = {z, 1'b1, ~in_data.c4, ~in_data.c8};
				fo.wr    = 1'b0;
			end
			c8alu_pkg::OP_AND:  fo.flags = {z, 1'b0, 1'b1, 1'b0};
			c8alu_pkg::OP_XOR, c8alu_pkg::OP_OR, c8alu_pkg::OP_SWAP:
				fo.flags = {z, 3'b000};
			c8alu_pkg::OP_INC:  fo.flags = {z, 1'b0, in_data.c4, cin};
			c8alu_pkg::OP_DEC:  fo.flags = {z, 1'b1, ~in_data.c4, cin};
			c8alu_pkg::OP_RLCA, c8alu_pkg::OP_RRCA, c8alu_pkg::OP_RLA, c8alu_pkg::OP_RRA:
				fo.flags = {3'b000, in_data.sout};
			c8alu_pkg::OP_DAA:
				fo.flags = {z, fin[c8alu_pkg::FLAG_N], 1'b0, in_data.daa_c};
			c8alu_pkg::OP_CPL:  fo.flags = {fin[c8alu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
			c8alu_pkg::OP_SCF: begin
				fo.flags = {fin[c8alu_pkg::FLAG_Z], 3'b001};
				fo.wr    = 1'b0;
			end
			c8alu_pkg::OP_CCF: begin
				fo.flags = {fin[c8alu_pkg::FLAG_Z], 2'b00, ~cin};
				fo.wr    = 1'b0;
			end
			c8alu_pkg::OP_RLC, c8alu_pkg::OP_RRC, c8alu_pkg::OP_RL, c8alu_pkg::OP_RR,
			c8alu_pkg::OP_SLA, c8alu_pkg::OP_SRA, c8alu_pkg::OP_SRL:
				fo.flags = {z, 2'b00, in_data.sout};
			c8alu_pkg::OP_BIT: begin
				fo.flags = {in_data.bitz, 1'b0, 1'b1, cin};
				fo.wr    = 1'b0;
			end
			c8alu_pkg::OP_RES, c8alu_pkg::OP_SET:
				fo.flags = fin;
			c8alu_pkg::OP_ADD16:
				fo.flags = {fin[c8alu_pkg::FLAG_Z], 1'b0, in_data.c12, in_data.c16};
			c8alu_pkg::OP_ADD16S:
				fo.flags = {2'b00, in_data.c4, in_data.c8};
			default: begin
				fo.res = '0;
				fo.wr  = 1'b0;
			end
		endcase
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= fo;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule
